/* sv/efr_pkg.sv */
// efr_pkg: shared constants and types for the escaped frame receiver
// framing characters, result kind codes, parser state encoding
// no dependencies
package efr_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 256;

    localparam logic [7:0] ESC_CHAR   = 8'h5C;   // backslash
    localparam logic [7:0] START_CHAR = 8'h53;   // 'S'
    localparam logic [7:0] END_CHAR   = 8'h45;   // 'E'

    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 9;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_RESTART = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_START  = 4'b0010,
        ST_DATA   = 4'b0100,
        ST_ESCAPE = 4'b1000
    } parse_state_t;

endpackage

/* sv/escaped_frame_receiver.sv */
// escaped_frame_receiver: removes backslash escape framing from a byte stream
// and reports payload bytes, frame restarts and frame ends with length
// depends on efr_pkg
// the result of an input transfer is registered and appears on the m_ side in the next cycle
// throughput: one byte per cycle unless a held result stalls input; the parser state updates at the input transfer
// a held result blocks input only while m_tready is low
// reset (aresetn low, synchronous) clears the parser, counters, enable and m_tvalid
module escaped_frame_receiver #(
    parameter int BUFFER_DEPTH = efr_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration: receive_enable
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data,      // [0] receive_enable

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [7:0] data_byte, [15:8] position,
                                       // [24:16] frame_length, [25] overflow, rest 0
    output logic [1:0]  m_tuser        // [1:0] kind
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int EXT_W = (CNT_W > efr_pkg::LEN_W) ? CNT_W : efr_pkg::LEN_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    logic                   enable_reg;
    efr_pkg::parse_state_t  state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   dropped_reg, dropped_next;

    logic                   m_valid_reg;
    efr_pkg::kind_t         kind_reg, kind_next;
    logic [7:0]             data_reg, data_next;
    logic [7:0]             pos_reg, pos_next;
    logic [8:0]             len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic                   res_valid;

    logic                   s_accept;
    logic                   buf_full;
    logic [EXT_W-1:0]       cnt_ext;
    logic [7:0]             rx_byte;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign rx_byte   = s_tdata;
    assign buf_full  = (count_reg >= DEPTH_CNT);
    assign cnt_ext   = EXT_W'(count_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        res_valid    = 1'b0;
        kind_next    = efr_pkg::KIND_PAYLOAD;
        data_next    = '0;
        pos_next     = '0;
        len_next     = '0;
        ovf_next     = 1'b0;

        if (s_accept && enable_reg) begin
            case (state_reg)
                efr_pkg::ST_IDLE: begin
                    if (rx_byte == efr_pkg::ESC_CHAR) begin
                        state_next = efr_pkg::ST_START;
                    end
                end
                efr_pkg::ST_START: begin
                    if (rx_byte == efr_pkg::START_CHAR) begin
                        state_next   = efr_pkg::ST_DATA;
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end else if (rx_byte != efr_pkg::ESC_CHAR) begin
                        state_next = efr_pkg::ST_IDLE;
                    end
                end
                efr_pkg::ST_DATA: begin
                    if (rx_byte == efr_pkg::ESC_CHAR) begin
                        state_next = efr_pkg::ST_ESCAPE;
                    end else if (buf_full) begin
                        dropped_next = 1'b1;
                    end else begin
                        res_valid  = 1'b1;
                        data_next  = rx_byte;
                        pos_next   = cnt_ext[7:0];
                        count_next = count_reg + CNT_ONE;
                    end
                end
                efr_pkg::ST_ESCAPE: begin
                    if (rx_byte == efr_pkg::START_CHAR) begin
                        state_next   = efr_pkg::ST_DATA;
                        count_next   = '0;
                        dropped_next = 1'b0;
                        res_valid    = 1'b1;
                        kind_next    = efr_pkg::KIND_RESTART;
                    end else if (rx_byte == efr_pkg::END_CHAR) begin
                        state_next = efr_pkg::ST_IDLE;
                        res_valid  = 1'b1;
                        kind_next  = efr_pkg::KIND_END;
                        len_next   = cnt_ext[8:0];
                        ovf_next   = dropped_reg;
                    end else begin
                        // escaped literal byte
                        state_next = efr_pkg::ST_DATA;
                        if (buf_full) begin
                            dropped_next = 1'b1;
                        end else begin
                            res_valid  = 1'b1;
                            data_next  = rx_byte;
                            pos_next   = cnt_ext[7:0];
                            count_next = count_reg + CNT_ONE;
                        end
                    end
                end
                default: begin
                    state_next = efr_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            state_reg   <= efr_pkg::ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                enable_reg <= cfg_data[0];
            end
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            // output slot is free or being emptied this cycle
            if (s_tready) begin
                m_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && res_valid) begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {6'd0, ovf_reg, len_reg, pos_reg, data_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("stored byte count above buffer depth");

    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && enable_reg && state_reg == efr_pkg::ST_DATA
         && rx_byte != efr_pkg::ESC_CHAR && !buf_full)
        |=> (count_reg == $past(count_reg) + CNT_ONE) && m_valid_reg)
        else $error("payload byte did not advance the count");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && enable_reg && state_reg == efr_pkg::ST_ESCAPE
         && rx_byte == efr_pkg::START_CHAR)
        |=> count_reg == '0 && !dropped_reg && state_reg == efr_pkg::ST_DATA
            && m_valid_reg && m_tuser == efr_pkg::KIND_RESTART)
        else $error("restart did not clear the frame");

    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && enable_reg && state_reg == efr_pkg::ST_ESCAPE
         && rx_byte == efr_pkg::END_CHAR)
        |=> state_reg == efr_pkg::ST_IDLE && m_valid_reg
            && m_tuser == efr_pkg::KIND_END)
        else $error("frame end not reported");

    a_drop_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(dropped_reg) |-> $past(count_reg) == DEPTH_CNT)
        else $error("overflow flagged with room left");

endmodule
